[design/vna_pkg.sv]
// Shared types, constants and state codes for the vertex normal accumulator.
package vna_pkg;

    localparam int VertexSlots = 1024;
    localparam int IdxBits     = 10;
    localparam int CoordBits   = 16;
    localparam int SumBits     = 40;
    localparam int EdgeBits    = CoordBits + 1;
    localparam int ProdBits    = 2 * EdgeBits;
    localparam int NormBits    = ProdBits + 1;
    localparam int QOne        = 16384;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_TRI   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [9:0]         vertex_index;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [9:0]         corner_a;
        logic [9:0]         corner_b;
        logic [9:0]         corner_c;
    } in_item_t;

    typedef struct packed {
        logic [9:0]         read_index;
        logic signed [15:0] unit_x;
        logic signed [15:0] unit_y;
        logic signed [15:0] unit_z;
        logic               degenerate;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PA, ST_PB, ST_PC, ST_EDGE,
        ST_MUL,
        ST_RMW_RD, ST_RMW_WAIT, ST_RMW_WR,
        ST_SUM_RD, ST_SUM_WAIT, ST_MAG, ST_SHIFT,
        ST_SQ, ST_SQRT, ST_DIV, ST_DONE
    } state_t;

    // Saturating add of a face normal component to a stored sum.
    function automatic logic signed [SumBits-1:0] sat_add(
        input logic signed [SumBits-1:0]  a,
        input logic signed [NormBits-1:0] b
    );
        logic signed [SumBits:0] s;
        s = {a[SumBits-1], a} + (SumBits+1)'(b);
        if (s[SumBits] != s[SumBits-1])
            sat_add = s[SumBits] ? {1'b1, {(SumBits-1){1'b0}}}
                                 : {1'b0, {(SumBits-1){1'b1}}};
        else
            sat_add = s[SumBits-1:0];
    endfunction

endpackage

[design/vertex_normal_accumulator.sv]
// Top level of the vertex normal accumulator: sequencer, stores and datapath.
//
// Usage: drive a beat on in_item and raise start while busy is low; the beat
// is taken at that edge and busy is high from the next cycle until the command
// ends. One command is in flight at a time. The steps of each command:
//   write position - the position store is written at the accepting edge.
//   add triangle   - three position reads, the cross product on the shared
//                    multiplier (six products over seven steps), then three
//                    read-modify-write passes over the sum store.
//   read normal    - sum read and magnitude scaling, three squares on the
//                    shared multiplier, a 32-step square root and three
//                    48-step divisions; the squares, root and divisions are
//                    skipped when the sum is zero.
//   clear sums     - one sum entry per cycle.
// A read gives one result beat with result_valid high for one cycle, the first
// cycle with busy low; the receiver cannot stall and must take the beat then.
// After reset the block clears the sum store (busy high) before
// the first beat is accepted. Positions are undefined until written.
module vertex_normal_accumulator
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  vna_pkg::in_item_t  in_item,
    output logic               result_valid,
    output vna_pkg::out_item_t result
);

    localparam int SB = vna_pkg::SumBits;
    localparam int CB = vna_pkg::CoordBits;
    localparam int NB = vna_pkg::NormBits;

    vna_pkg::state_t state_reg, state_next;
    vna_pkg::in_item_t item_reg;

    logic [3*CB-1:0]   pos_mem [vna_pkg::VertexSlots];
    logic [3*SB-1:0]   sum_mem [vna_pkg::VertexSlots];
    logic [3*CB-1:0]   pos_rd_reg;
    logic [3*SB-1:0]   sum_rd_reg;

    logic [vna_pkg::IdxBits-1:0] clr_reg;
    logic [vna_pkg::IdxBits-1:0] pos_addr;
    logic [vna_pkg::IdxBits-1:0] sum_addr;
    logic        sum_we;
    logic [3*SB-1:0] sum_wdata;

    logic signed [CB-1:0] pa_reg [3];
    logic signed [CB:0]   e1_reg [3];
    logic signed [CB:0]   e2_reg [3];
    logic signed [NB-1:0] n_reg  [3];
    logic signed [2*CB+1:0] prod_reg;
    logic [2:0]  step_reg;
    logic [1:0]  corner_reg;

    logic [SB-1:0] mag_reg [3];
    logic [2:0]    neg_reg;
    logic [29:0]   m_reg   [3];
    logic [63:0]   sq_reg;
    logic [1:0]    comp_reg;
    logic [15:0]   q_reg   [3];
    logic [5:0]    shamt;
    logic          shl;

    // Shared multiplier: 33x33 signed.
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    assign mul_p = mul_a * mul_b;

    // Running sum of squares; the last square goes straight to the root unit.
    logic [63:0] sq_sum;
    assign sq_sum = ((comp_reg == 2'd0) ? 64'd0 : sq_reg) + 64'(mul_p[59:0]);

    logic        sq_go, sq_done, dv_go, dv_done;
    logic [31:0] sq_root;
    logic [15:0] dv_q;
    logic        dv_wait_reg;

    // A division started from ST_DIV is for the component after the one finishing.
    logic [1:0]  div_comp;
    assign div_comp = (state_reg == vna_pkg::ST_DIV) ? comp_reg + 2'd1 : comp_reg;

    vna_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .go(sq_go), .radicand(sq_sum),
                     .done(sq_done), .root(sq_root));

    vna_div u_div (.clk(clk), .rst_n(rst_n), .go(dv_go),
                   .dividend({3'b0, m_reg[div_comp], 15'b0} + {16'b0, sq_root}),
                   .divisor({sq_root, 1'b0}), .done(dv_done), .quotient(dv_q));

    always_comb
    begin
        case (step_reg[2:0])
            3'd0: begin mul_a = 33'(e1_reg[1]); mul_b = 33'(e2_reg[2]); end
            3'd1: begin mul_a = 33'(e1_reg[2]); mul_b = 33'(e2_reg[1]); end
            3'd2: begin mul_a = 33'(e1_reg[2]); mul_b = 33'(e2_reg[0]); end
            3'd3: begin mul_a = 33'(e1_reg[0]); mul_b = 33'(e2_reg[2]); end
            3'd4: begin mul_a = 33'(e1_reg[0]); mul_b = 33'(e2_reg[1]); end
            default: begin mul_a = 33'(e1_reg[1]); mul_b = 33'(e2_reg[0]); end
        endcase
        if (state_reg == vna_pkg::ST_SQ)
        begin
            mul_a = {3'b0, m_reg[comp_reg]};
            mul_b = {3'b0, m_reg[comp_reg]};
        end
    end

    // Normalizing shift: find position of the leading one of the max magnitude.
    logic [SB-1:0] mx;
    always_comb
    begin
        mx = mag_reg[0];
        if (mag_reg[1] > mx) mx = mag_reg[1];
        if (mag_reg[2] > mx) mx = mag_reg[2];
        shamt = '0;
        shl   = 1'b1;
        for (int i = 0; i < SB; i++)
            if (mx[i])
            begin
                if (i >= 29) begin shl = 1'b0; shamt = 6'(i - 29); end
                else         begin shl = 1'b1; shamt = 6'(29 - i); end
            end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vna_pkg::ST_IDLE:
                if (start)
                begin
                    case (vna_pkg::cmd_t'(in_item.command))
                        vna_pkg::CMD_WRITE: state_next = vna_pkg::ST_DONE;
                        vna_pkg::CMD_TRI:   state_next = vna_pkg::ST_PA;
                        vna_pkg::CMD_READ:  state_next = vna_pkg::ST_SUM_RD;
                        default:            state_next = vna_pkg::ST_CLEAR;
                    endcase
                end
            vna_pkg::ST_CLEAR:
                if (clr_reg == 10'h3FF) state_next = vna_pkg::ST_IDLE;
            vna_pkg::ST_PA:   state_next = vna_pkg::ST_PB;
            vna_pkg::ST_PB:   state_next = vna_pkg::ST_PC;
            vna_pkg::ST_PC:   state_next = vna_pkg::ST_EDGE;
            vna_pkg::ST_EDGE: state_next = vna_pkg::ST_MUL;
            vna_pkg::ST_MUL:
                if (step_reg == 3'd6) state_next = vna_pkg::ST_RMW_RD;
            vna_pkg::ST_RMW_RD:   state_next = vna_pkg::ST_RMW_WAIT;
            vna_pkg::ST_RMW_WAIT: state_next = vna_pkg::ST_RMW_WR;
            vna_pkg::ST_RMW_WR:
                state_next = (corner_reg == 2'd2) ? vna_pkg::ST_IDLE
                                                  : vna_pkg::ST_RMW_RD;
            vna_pkg::ST_SUM_RD:   state_next = vna_pkg::ST_SUM_WAIT;
            vna_pkg::ST_SUM_WAIT: state_next = vna_pkg::ST_MAG;
            vna_pkg::ST_MAG:
                state_next = (sum_rd_reg == '0) ? vna_pkg::ST_DONE
                                                : vna_pkg::ST_SHIFT;
            vna_pkg::ST_SHIFT: state_next = vna_pkg::ST_SQ;
            vna_pkg::ST_SQ:
                if (comp_reg == 2'd2) state_next = vna_pkg::ST_SQRT;
            vna_pkg::ST_SQRT:
                if (dv_wait_reg) state_next = vna_pkg::ST_DIV;
            vna_pkg::ST_DIV:
                if (dv_wait_reg && comp_reg == 2'd2) state_next = vna_pkg::ST_DONE;
            vna_pkg::ST_DONE: state_next = vna_pkg::ST_IDLE;
            default: state_next = vna_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        busy      = (state_reg != vna_pkg::ST_IDLE);
        sum_we    = 1'b0;
        sum_addr  = item_reg.vertex_index;
        pos_addr  = item_reg.corner_a;
        sum_wdata = '0;
        sq_go     = 1'b0;
        dv_go     = 1'b0;
        case (state_reg)
            vna_pkg::ST_CLEAR:
            begin
                sum_we   = 1'b1;
                sum_addr = clr_reg;
            end
            vna_pkg::ST_PA: pos_addr = item_reg.corner_a;
            vna_pkg::ST_PB: pos_addr = item_reg.corner_b;
            vna_pkg::ST_PC: pos_addr = item_reg.corner_c;
            vna_pkg::ST_RMW_RD, vna_pkg::ST_RMW_WAIT, vna_pkg::ST_RMW_WR:
            begin
                case (corner_reg)
                    2'd0:    sum_addr = item_reg.corner_a;
                    2'd1:    sum_addr = item_reg.corner_b;
                    default: sum_addr = item_reg.corner_c;
                endcase
                if (state_reg == vna_pkg::ST_RMW_WR)
                begin
                    sum_we    = 1'b1;
                    sum_wdata = {vna_pkg::sat_add(sum_rd_reg[3*SB-1:2*SB], n_reg[0]),
                                 vna_pkg::sat_add(sum_rd_reg[2*SB-1:SB], n_reg[1]),
                                 vna_pkg::sat_add(sum_rd_reg[SB-1:0], n_reg[2])};
                end
            end
            vna_pkg::ST_SQ: sq_go = (comp_reg == 2'd2);
            vna_pkg::ST_SQRT: dv_go = dv_wait_reg;
            vna_pkg::ST_DIV: dv_go = dv_wait_reg && (comp_reg != 2'd2);
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == vna_pkg::ST_IDLE && start &&
            in_item.command == vna_pkg::CMD_WRITE)
            pos_mem[in_item.vertex_index] <= {in_item.pos_x, in_item.pos_y,
                                              in_item.pos_z};
        pos_rd_reg <= pos_mem[pos_addr];
        if (sum_we)
            sum_mem[sum_addr] <= sum_wdata;
        sum_rd_reg <= sum_mem[sum_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= vna_pkg::ST_CLEAR;
            clr_reg     <= '0;
            step_reg    <= '0;
            corner_reg  <= '0;
            comp_reg    <= '0;
            dv_wait_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == vna_pkg::ST_CLEAR) clr_reg <= clr_reg + 10'd1;
            else clr_reg <= '0;
            if (state_reg == vna_pkg::ST_MUL) step_reg <= step_reg + 3'd1;
            else step_reg <= '0;
            if (state_reg == vna_pkg::ST_RMW_WR) corner_reg <= corner_reg + 2'd1;
            else if (state_reg == vna_pkg::ST_IDLE) corner_reg <= '0;
            if (state_reg == vna_pkg::ST_SQ)
                comp_reg <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
            else if (state_reg == vna_pkg::ST_DIV && dv_wait_reg)
                comp_reg <= comp_reg + 2'd1;
            else if (state_reg == vna_pkg::ST_IDLE)
                comp_reg <= '0;
            // A unit's done flag is registered so its final bit has settled.
            dv_wait_reg <= sq_done || dv_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == vna_pkg::ST_IDLE && start)
            item_reg <= in_item;
        case (state_reg)
            vna_pkg::ST_PB: pa_reg <= '{signed'(pos_rd_reg[47:32]),
                                        signed'(pos_rd_reg[31:16]),
                                        signed'(pos_rd_reg[15:0])};
            vna_pkg::ST_PC:
                for (int i = 0; i < 3; i++)
                    e1_reg[i] <= 17'(signed'(pos_rd_reg[47-16*i -: 16])) -
                                 17'(pa_reg[i]);
            vna_pkg::ST_EDGE:
                for (int i = 0; i < 3; i++)
                    e2_reg[i] <= 17'(signed'(pos_rd_reg[47-16*i -: 16])) -
                                 17'(pa_reg[i]);
            vna_pkg::ST_MUL:
            begin
                if (step_reg < 3'd6)
                    prod_reg <= mul_p[33:0];
                if (step_reg[0] == 1'b1)
                    n_reg[step_reg[2:1]] <= 35'(prod_reg) -
                                            35'(signed'(mul_p[33:0]));
            end
            vna_pkg::ST_MAG:
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[i] <= sum_rd_reg[3*SB-1-SB*i];
                    mag_reg[i] <= sum_rd_reg[3*SB-1-SB*i]
                                ? SB'(-signed'(sum_rd_reg[3*SB-1-SB*i -: SB]))
                                : sum_rd_reg[3*SB-1-SB*i -: SB];
                end
            vna_pkg::ST_SHIFT:
                for (int i = 0; i < 3; i++)
                    m_reg[i] <= shl ? 30'(mag_reg[i] << shamt)
                                    : 30'(mag_reg[i] >> shamt);
            vna_pkg::ST_SQ:
                sq_reg <= sq_sum;
            vna_pkg::ST_DIV:
                if (dv_wait_reg) q_reg[comp_reg] <= dv_q;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid <= 1'b0;
        else
            result_valid <= (state_reg == vna_pkg::ST_DONE) &&
                            (item_reg.command == vna_pkg::CMD_READ);
    end

    always_ff @(posedge clk)
    begin
        result.read_index <= item_reg.vertex_index;
        result.degenerate <= (sum_rd_reg == '0);
        result.unit_x <= (sum_rd_reg == '0) ? 16'sd0 :
                         neg_reg[0] ? -signed'(q_reg[0]) : signed'(q_reg[0]);
        result.unit_y <= (sum_rd_reg == '0) ? 16'sd0 :
                         neg_reg[1] ? -signed'(q_reg[1]) : signed'(q_reg[1]);
        result.unit_z <= (sum_rd_reg == '0) ? 16'sd0 :
                         neg_reg[2] ? -signed'(q_reg[2]) : signed'(q_reg[2]);
    end

`ifndef SYNTHESIS
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == vna_pkg::ST_DONE))
        else $error("result beat without a finished read");
    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not start a command");
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result held for more than one beat");
`endif

endmodule

[design/vna_sqrt.sv]
// Bit-serial integer square root, one result bit per cycle.
module vna_sqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] rem_reg;
    logic [31:0] root_reg, root_next;
    logic [31:0] wrem_reg;
    logic [33:0] wrem_next;
    logic [33:0] wcat;
    logic [33:0] trial;
    logic [5:0]  cnt_reg;
    logic        run_reg;

    // Restoring method: bring down two radicand bits per step and try (4*root + 1).
    // The radicand stays below 2^62, so the running remainder fits in 32 bits.
    always_comb
    begin
        wcat      = {wrem_reg, rem_reg[63:62]};
        trial     = {root_reg, 2'b01};
        wrem_next = wcat;
        root_next = {root_reg[30:0], 1'b0};
        if (wcat >= trial)
        begin
            wrem_next = wcat - trial;
            root_next = {root_reg[30:0], 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (go)
        begin
            run_reg <= 1'b1;
            cnt_reg <= 6'd32;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg  <= radicand;
            root_reg <= '0;
            wrem_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg  <= {rem_reg[61:0], 2'b00};
            root_reg <= root_next;
            wrem_reg <= wrem_next[31:0];
        end
    end

    assign done = run_reg && (cnt_reg == 6'd1);
    assign root = root_reg;

endmodule

[design/vna_div.sv]
// Restoring divider, one quotient bit per cycle.
module vna_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [47:0] dividend,
    input  logic [32:0] divisor,
    output logic        done,
    output logic [15:0] quotient
);

    logic [47:0] num_reg;
    logic [33:0] rem_reg;
    logic [32:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        run_reg;
    logic [33:0] shifted;

    assign shifted = {rem_reg[32:0], num_reg[47]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (go)
        begin
            run_reg <= 1'b1;
            cnt_reg <= 6'd48;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (run_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_reg <= shifted - {1'b0, den_reg};
                num_reg <= {num_reg[46:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                num_reg <= {num_reg[46:0], 1'b0};
            end
        end
    end

    assign done     = run_reg && (cnt_reg == 6'd1);
    // Quotient never exceeds 16384 so low bits suffice; the last bit is shifted in at the edge on which done is high.
    assign quotient = num_reg[15:0];

endmodule

[bench/tb.sv]
// Testbench for the vertex normal accumulator: directed table, then random commands.
`timescale 1ns / 1ps

module tb;

    typedef struct {
        vna_pkg::in_item_t  item;
        bit                 typed;
        vna_pkg::out_item_t want;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    vna_pkg::in_item_t  in_item;
    logic               result_valid;
    vna_pkg::out_item_t result;

    // Shadow copies of the two stores.
    longint             coord_mem[vna_pkg::VertexSlots][3];
    longint             normal_sum[vna_pkg::VertexSlots][3];
    bit                 pos_written[vna_pkg::VertexSlots];
    int                 written_list[$];
    vna_pkg::out_item_t normal_queue[$];
    stim_row_t          stim_table[$];
    int                 mismatches;
    int                 hot[3];

    vertex_normal_accumulator dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .in_item(in_item),
        .result_valid(result_valid),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #30ms;
        $display("simulation failed");
        $finish;
    end

    function automatic longint sum_sat(longint a, longint b);
        longint hi;
        longint s;
        hi = (longint'(1) <<< (vna_pkg::SumBits - 1)) - 1;
        s = a + b;
        if (s > hi)
            return hi;
        if (s < -hi - 1)
            return -hi - 1;
        return s;
    endfunction

    function automatic void add_face(int a, int b, int c);
        longint e1[3];
        longint e2[3];
        longint n[3];
        int     corner[3];
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = coord_mem[b][i] - coord_mem[a][i];
            e2[i] = coord_mem[c][i] - coord_mem[a][i];
        end
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        corner = '{a, b, c};
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++)
                normal_sum[corner[k]][i] = sum_sat(normal_sum[corner[k]][i], n[i]);
    endfunction

    function automatic vna_pkg::out_item_t unit_normal(int idx);
        vna_pkg::out_item_t r;
        longint unsigned m[3];
        longint unsigned mx;
        longint unsigned sq;
        longint unsigned len;
        longint unsigned bitv;
        longint unsigned rem;
        longint unsigned v;
        bit             neg[3];
        logic [15:0]    u[3];
        mx = 0;
        r = '0;
        r.read_index = idx[9:0];
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = normal_sum[idx][i] < 0;
            m[i] = neg[i] ? longint'(-normal_sum[idx][i]) : normal_sum[idx][i];
            if (m[i] > mx)
                mx = m[i];
        end
        if (mx == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        while (mx >= (64'd1 << 30))
        begin
            mx >>= 1;
            for (int i = 0; i < 3; i++)
                m[i] >>= 1;
        end
        while (mx < (64'd1 << 29))
        begin
            mx <<= 1;
            for (int i = 0; i < 3; i++)
                m[i] <<= 1;
        end
        sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        // Bitwise integer square root.
        len = 0;
        rem = sq;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (rem >= len + bitv)
            begin
                rem -= len + bitv;
                len = (len >> 1) + bitv;
            end
            else
                len >>= 1;
            bitv >>= 2;
        end
        for (int i = 0; i < 3; i++)
        begin
            v = (2 * m[i] * vna_pkg::QOne + len) / (2 * len);
            u[i] = neg[i] ? 16'(-v) : 16'(v);
        end
        r.unit_x = u[0];
        r.unit_y = u[1];
        r.unit_z = u[2];
        return r;
    endfunction

    // Applies one accepted command to the shadow state; returns 1 for a read.
    function automatic bit apply_command(vna_pkg::in_item_t it,
                                         output vna_pkg::out_item_t r);
        r = '0;
        case (vna_pkg::cmd_t'(it.command))
            vna_pkg::CMD_WRITE:
            begin
                coord_mem[it.vertex_index] = '{it.pos_x, it.pos_y, it.pos_z};
                if (!pos_written[it.vertex_index])
                    written_list = {written_list, int'(it.vertex_index)};
                pos_written[it.vertex_index] = 1'b1;
            end
            vna_pkg::CMD_TRI:
                add_face(it.corner_a, it.corner_b, it.corner_c);
            vna_pkg::CMD_READ:
            begin
                r = unit_normal(it.vertex_index);
                return 1'b1;
            end
            vna_pkg::CMD_CLEAR:
                foreach (normal_sum[i, j])
                    normal_sum[i][j] = 0;
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic vna_pkg::in_item_t rand_item();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(vna_pkg::in_item_t)-1:0];
    endfunction

    function automatic vna_pkg::in_item_t write_item(int idx, int x, int y, int z);
        vna_pkg::in_item_t it;
        it = rand_item();
        it.command = vna_pkg::CMD_WRITE;
        it.vertex_index = idx[9:0];
        it.pos_x = x[15:0];
        it.pos_y = y[15:0];
        it.pos_z = z[15:0];
        return it;
    endfunction

    function automatic vna_pkg::in_item_t tri_item(int a, int b, int c);
        vna_pkg::in_item_t it;
        it = rand_item();
        it.command = vna_pkg::CMD_TRI;
        it.corner_a = a[9:0];
        it.corner_b = b[9:0];
        it.corner_c = c[9:0];
        return it;
    endfunction

    function automatic vna_pkg::in_item_t read_item(int idx);
        vna_pkg::in_item_t it;
        it = rand_item();
        it.command = vna_pkg::CMD_READ;
        it.vertex_index = idx[9:0];
        return it;
    endfunction

    function automatic vna_pkg::in_item_t clear_item();
        vna_pkg::in_item_t it;
        it = rand_item();
        it.command = vna_pkg::CMD_CLEAR;
        return it;
    endfunction

    function automatic void add_row(vna_pkg::in_item_t it, bit typed = 0);
        stim_row_t row;
        row.item = it;
        row.typed = typed;
        row.want = '0;
        row.want.read_index = it.vertex_index;
        row.want.degenerate = 1'b1;
        stim_table = {stim_table, row};
    endfunction

    // Holds the beat on the inputs until busy, sampled at the clock, reads low.
    task automatic issue(vna_pkg::in_item_t it, bit typed, vna_pkg::out_item_t want);
        vna_pkg::out_item_t r;
        start <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (busy);
        if (apply_command(it, r))
            normal_queue = {normal_queue, (typed ? want : r)};
    endtask

    task automatic send_random(int count);
        vna_pkg::in_item_t  it;
        vna_pkg::out_item_t none;
        int        sel;
        int        rot;
        bit        quiet;
        none = '0;
        quiet = 0;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                quiet = $urandom_range(0, 2) == 0;
            sel = $urandom_range(0, 99);
            if (sel < 22 || written_list.size() == 0)
            begin
                it = write_item($urandom_range(0, 1023), $urandom, $urandom, $urandom);
                if ($urandom_range(0, 3) == 0)
                begin
                    it.pos_x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                    it.pos_y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                end
            end
            else if (sel < 42)
            begin
                // Same orientation each time, so the hot sums grow into saturation.
                rot = $urandom_range(0, 2);
                it = tri_item(hot[rot], hot[(rot + 1) % 3], hot[(rot + 2) % 3]);
            end
            else if (sel < 68)
                it = tri_item(written_list[$urandom_range(0, written_list.size() - 1)],
                              written_list[$urandom_range(0, written_list.size() - 1)],
                              written_list[$urandom_range(0, written_list.size() - 1)]);
            else if (sel < 97)
            begin
                it = read_item($urandom_range(0, 1023));
                if ($urandom_range(0, 2) != 0)
                    it.vertex_index =
                        10'(written_list[$urandom_range(0, written_list.size() - 1)]);
            end
            else
                it = clear_item();
            issue(it, 1'b0, none);
            if (!quiet && count - n > 100 && $urandom_range(0, 2) == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
        end
    endtask

    always @(posedge clk)
    begin
        vna_pkg::out_item_t want;
        if (rst_n && result_valid)
        begin
            if (normal_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %p", result);
            end
            else
            begin
                want = normal_queue.pop_front();
                if (result.read_index !== want.read_index || result.unit_x !== want.unit_x
                    || result.unit_y !== want.unit_y || result.unit_z !== want.unit_z
                    || result.degenerate !== want.degenerate)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("normal mismatch: expected %p, got %p", want, result);
                end
            end
        end
    end

    initial
    begin
        vna_pkg::out_item_t none;
        none = '0;
        mismatches = 0;
        rst_n <= 1'b0;
        start <= 1'b0;
        in_item <= '0;
        foreach (normal_sum[i, j])
        begin
            normal_sum[i][j] = 0;
            coord_mem[i][j] = 0;
        end
        hot = '{5, 6, 7};

        // Extremes, degenerate sums, collinear and repeated corners, clear.
        add_row(read_item(0), 1);
        add_row(read_item(1023), 1);
        add_row(write_item(0, 0, 0, 0));
        add_row(write_item(1, 32767, 0, 0));
        add_row(write_item(2, 0, 32767, 0));
        add_row(write_item(1023, 32767, 32767, 32767));
        add_row(write_item(3, -32768, -32768, -32768));
        add_row(write_item(512, -1, -1, -1));
        add_row(tri_item(0, 1, 2));
        add_row(read_item(0));
        add_row(read_item(1));
        add_row(tri_item(0, 3, 1023));
        add_row(read_item(3), 1);
        add_row(tri_item(1023, 1023, 512));
        add_row(read_item(512), 1);
        add_row(tri_item(3, 1, 2));
        add_row(tri_item(1, 2, 1023));
        add_row(read_item(1023));
        add_row(read_item(2));
        add_row(write_item(5, -32768, -32768, 0));
        add_row(write_item(6, 32767, -32768, 32767));
        add_row(write_item(7, -32768, 32767, -32768));
        add_row(clear_item());
        add_row(read_item(0), 1);
        add_row(read_item(1), 1);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        foreach (stim_table[i])
        begin
            issue(stim_table[i].item, stim_table[i].typed, stim_table[i].want);
            if ($urandom_range(0, 1) == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
        end
        send_random(830);
        start <= 1'b0;

        while (normal_queue.size() != 0)
            @(posedge clk);
        repeat (1200) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
